### rtl/vbmu_pkg.sv
// Package for the video bank mapping unit: bank count, region and function codes,
// per-bank write masks and the bank window decoder function.
// No dependencies.
package vbmu_pkg;

  localparam int unsigned NUM_BANKS = 9;
  localparam int unsigned BIDX_W    = 4;
  localparam int unsigned CTL_W     = 8;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned OFS_W     = 17;
  localparam int unsigned SIZE_W    = 18;

  // function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  // region codes
  localparam logic [2:0] RG_LCDC = 3'd0;
  localparam logic [2:0] RG_BGA  = 3'd1;
  localparam logic [2:0] RG_OBJA = 3'd2;
  localparam logic [2:0] RG_BGB  = 3'd3;
  localparam logic [2:0] RG_OBJB = 3'd4;
  localparam logic [2:0] RG_SUB  = 3'd5;
  localparam logic [2:0] RG_TEX  = 3'd6;
  localparam logic [2:0] RG_TPAL = 3'd7;

  // bank control mode codes
  localparam logic [2:0] MODE_0 = 3'd0;
  localparam logic [2:0] MODE_1 = 3'd1;
  localparam logic [2:0] MODE_2 = 3'd2;
  localparam logic [2:0] MODE_3 = 3'd3;
  localparam logic [2:0] MODE_4 = 3'd4;

  // bank numbers with special handling
  localparam logic [BIDX_W-1:0] BANK_C = 4'd2;
  localparam logic [BIDX_W-1:0] BANK_D = 4'd3;
  localparam logic [BIDX_W-1:0] BANK_E = 4'd4;
  localparam logic [BIDX_W-1:0] BANK_F = 4'd5;
  localparam logic [BIDX_W-1:0] BANK_G = 4'd6;
  localparam logic [BIDX_W-1:0] BANK_H = 4'd7;
  localparam logic [BIDX_W-1:0] BANK_I = 4'd8;

  // window sizes
  localparam logic [SIZE_W-1:0] SIZE_128K = 18'h20000;
  localparam logic [SIZE_W-1:0] SIZE_64K  = 18'h10000;
  localparam logic [SIZE_W-1:0] SIZE_32K  = 18'h08000;
  localparam logic [SIZE_W-1:0] SIZE_16K  = 18'h04000;

  // fixed window bases
  localparam logic [ADDR_W-1:0] BASE_E_LCDC = 20'h80000;
  localparam logic [ADDR_W-1:0] BASE_F_LCDC = 20'h90000;
  localparam logic [ADDR_W-1:0] BASE_G_LCDC = 20'h94000;
  localparam logic [ADDR_W-1:0] BASE_H_LCDC = 20'h98000;
  localparam logic [ADDR_W-1:0] BASE_I_LCDC = 20'ha0000;
  localparam logic [ADDR_W-1:0] BASE_I_BGB  = 20'h08000;

  typedef logic [NUM_BANKS-1:0][CTL_W-1:0] ctl_arr_t;

  // writable bits of each bank control byte
  localparam ctl_arr_t WRITE_MASKS = {
    8'h83, 8'h83, 8'h9f, 8'h9f, 8'h87, 8'h9f, 8'h9f, 8'h9b, 8'h9b
  };

  // one bank window
  typedef struct packed {
    logic              mapped;
    logic [2:0]        region;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } win_t;

  // translate result
  typedef struct packed {
    logic [NUM_BANKS-1:0] hit_mask;
    logic [BIDX_W-1:0]    first_bank;
    logic [OFS_W-1:0]     bank_offset;
  } xlat_t;

  // bank is enabled and given to the sub processor
  function automatic logic on_sub(input logic [CTL_W-1:0] ctl);
    return ctl[7] && (ctl[2:0] == MODE_2);
  endfunction

  // window that a control byte opens for bank b
  function automatic win_t bank_window(input logic [BIDX_W-1:0] b,
                                       input logic [CTL_W-1:0] ctl);
    win_t       w;
    logic [2:0] mode;
    logic       o0;
    logic       o1;
    mode     = ctl[2:0];
    o0       = ctl[3];
    o1       = ctl[4];
    w.mapped = 1'b0;
    w.region = RG_LCDC;
    w.base   = '0;
    w.size   = '0;
    if (b <= BANK_D) begin
      w.size = SIZE_128K;
      case (mode)
        MODE_0: begin
          w.mapped = 1'b1; w.region = RG_LCDC; w.base = {1'b0, b[1:0], 17'b0};
        end
        MODE_1: begin
          w.mapped = 1'b1; w.region = RG_BGA; w.base = {1'b0, o1, o0, 17'b0};
        end
        MODE_2: begin
          w.mapped = 1'b1;
          w.region = (b >= BANK_C) ? RG_SUB : RG_OBJA;
          w.base   = {2'b0, o0, 17'b0};
        end
        MODE_3: begin
          w.mapped = 1'b1; w.region = RG_TEX; w.base = {1'b0, o1, o0, 17'b0};
        end
        MODE_4: begin
          w.mapped = (b == BANK_C) || (b == BANK_D);
          w.region = (b == BANK_C) ? RG_BGB : RG_OBJB;
        end
        default: w.mapped = 1'b0;
      endcase
    end else if (b == BANK_E) begin
      w.size = SIZE_64K;
      case (mode)
        MODE_0: begin w.mapped = 1'b1; w.region = RG_LCDC; w.base = BASE_E_LCDC; end
        MODE_1: begin w.mapped = 1'b1; w.region = RG_BGA; end
        MODE_2: begin w.mapped = 1'b1; w.region = RG_OBJA; end
        MODE_3: begin w.mapped = 1'b1; w.region = RG_TPAL; end
        default: w.mapped = 1'b0;
      endcase
    end else if ((b == BANK_F) || (b == BANK_G)) begin
      w.size = SIZE_16K;
      case (mode)
        MODE_0: begin
          w.mapped = 1'b1; w.region = RG_LCDC;
          w.base   = (b == BANK_F) ? BASE_F_LCDC : BASE_G_LCDC;
        end
        MODE_1: begin
          w.mapped = 1'b1; w.region = RG_BGA; w.base = {3'b0, o1, 1'b0, o0, 14'b0};
        end
        MODE_2: begin
          w.mapped = 1'b1; w.region = RG_OBJA; w.base = {3'b0, o1, 1'b0, o0, 14'b0};
        end
        MODE_3: begin
          w.mapped = 1'b1; w.region = RG_TPAL; w.base = {3'b0, o1, 1'b0, o0, 14'b0};
        end
        default: w.mapped = 1'b0;
      endcase
    end else if (b == BANK_H) begin
      w.size = SIZE_32K;
      case (mode)
        MODE_0: begin w.mapped = 1'b1; w.region = RG_LCDC; w.base = BASE_H_LCDC; end
        MODE_1: begin w.mapped = 1'b1; w.region = RG_BGB; end
        default: w.mapped = 1'b0;
      endcase
    end else if (b == BANK_I) begin
      w.size = SIZE_16K;
      case (mode)
        MODE_0: begin w.mapped = 1'b1; w.region = RG_LCDC; w.base = BASE_I_LCDC; end
        MODE_1: begin w.mapped = 1'b1; w.region = RG_BGB; w.base = BASE_I_BGB; end
        MODE_2: begin w.mapped = 1'b1; w.region = RG_OBJB; end
        default: w.mapped = 1'b0;
      endcase
    end
    // disabled bank opens no window
    w.mapped = w.mapped && ctl[7];
    return w;
  endfunction

endpackage

### rtl/video_bank_mapping_unit_top.sv
// A beat accepted goes into the input register, and its result is then captured in the
// output register. Throughput: one beat per cycle while the result side does not stall;
// one pass of window compare and priority pick.
// Reset clears all bank control bytes, the sub processor status and both valid flags.
// Depends on vbmu_pkg and vbmu_decode.
module video_bank_mapping_unit_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [vbmu_pkg::BIDX_W-1:0]   bank_index_i,
  input  logic [vbmu_pkg::CTL_W-1:0]    control_value_i,
  input  logic [2:0]                    region_i,
  input  logic [vbmu_pkg::ADDR_W-1:0]   region_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vbmu_pkg::NUM_BANKS-1:0] hit_mask_o,
  output logic [vbmu_pkg::BIDX_W-1:0]   first_bank_o,
  output logic [vbmu_pkg::OFS_W-1:0]    bank_offset_o,
  output logic [1:0]                    status_bits_o,
  output logic [vbmu_pkg::CTL_W-1:0]    control_readback_o
);
  import vbmu_pkg::*;

  // input register
  logic              s1_valid_q;
  logic              s1_func_q;
  logic [BIDX_W-1:0] s1_bidx_q;
  logic [CTL_W-1:0]  s1_val_q;
  logic [2:0]        s1_region_q;
  logic [ADDR_W-1:0] s1_addr_q;

  // bank state
  ctl_arr_t   ctl_q;
  ctl_arr_t   ctl_d;
  logic [1:0] cpu_status_q;
  logic [1:0] status_d;

  // output register
  logic                 out_valid_q;
  logic [NUM_BANKS-1:0] hit_mask_q;
  logic [BIDX_W-1:0]    first_bank_q;
  logic [OFS_W-1:0]     bank_offset_q;
  logic [1:0]           status_q;
  logic [CTL_W-1:0]     readback_q;

  logic    out_load;
  logic    s1_fire;
  logic    bidx_ok;
  logic    do_write;
  xlat_t   xlat;
  logic [CTL_W-1:0] readback_d;

  // handshake
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_func_q   <= func_i;
      s1_bidx_q   <= bank_index_i;
      s1_val_q    <= control_value_i;
      s1_region_q <= region_i;
      s1_addr_q   <= region_address_i;
    end
  end

  // control write
  assign bidx_ok  = s1_bidx_q < BIDX_W'(NUM_BANKS);
  assign do_write = (s1_func_q == FUNC_WRITE) && bidx_ok;

  always_comb begin
    ctl_d    = ctl_q;
    status_d = cpu_status_q;
    if (do_write) begin
      ctl_d[s1_bidx_q] = s1_val_q & WRITE_MASKS[s1_bidx_q];
      status_d         = {on_sub(ctl_d[BANK_D]), on_sub(ctl_d[BANK_C])};
    end
  end

  assign readback_d = bidx_ok ? ctl_d[s1_bidx_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q        <= '0;
      cpu_status_q <= '0;
    end else if (s1_fire) begin
      ctl_q        <= ctl_d;
      cpu_status_q <= status_d;
    end
  end

  // translate
  vbmu_decode u_decode (
    .ctl_i    (ctl_q),
    .region_i (s1_region_q),
    .addr_i   (s1_addr_q),
    .xlat_o   (xlat)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      if (s1_func_q == FUNC_XLATE) begin
        hit_mask_q    <= xlat.hit_mask;
        first_bank_q  <= xlat.first_bank;
        bank_offset_q <= xlat.bank_offset;
      end else begin
        hit_mask_q    <= '0;
        first_bank_q  <= '0;
        bank_offset_q <= '0;
      end
      status_q   <= status_d;
      readback_q <= readback_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_mask_o         = hit_mask_q;
  assign first_bank_o       = first_bank_q;
  assign bank_offset_o      = bank_offset_q;
  assign status_bits_o      = status_q;
  assign control_readback_o = readback_q;

endmodule

### rtl/vbmu_decode.sv
// Address translate logic: checks all bank windows in parallel and picks the lowest hit.
// Depends on vbmu_pkg.
module vbmu_decode (
  input  vbmu_pkg::ctl_arr_t          ctl_i,
  input  logic [2:0]                  region_i,
  input  logic [vbmu_pkg::ADDR_W-1:0] addr_i,
  output vbmu_pkg::xlat_t             xlat_o
);
  import vbmu_pkg::*;

  logic [NUM_BANKS-1:0]            hit;
  logic [NUM_BANKS-1:0][OFS_W-1:0] ofs;

  // per-bank window compare
  for (genvar gi = 0; gi < NUM_BANKS; gi++) begin : g_bank
    win_t          win;
    logic [ADDR_W:0] diff;
    assign win  = bank_window(BIDX_W'(gi), ctl_i[gi]);
    assign diff = {1'b0, addr_i} - {1'b0, win.base};
    assign hit[gi] = win.mapped && (win.region == region_i) && !diff[ADDR_W]
                     && (diff[ADDR_W-1:0] < {{(ADDR_W-SIZE_W){1'b0}}, win.size});
    assign ofs[gi] = diff[OFS_W-1:0];
  end

  // lowest hit bank wins
  always_comb begin
    xlat_o.hit_mask    = hit;
    xlat_o.first_bank  = '0;
    xlat_o.bank_offset = '0;
    for (int i = NUM_BANKS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        xlat_o.first_bank  = BIDX_W'(i);
        xlat_o.bank_offset = ofs[i];
      end
    end
  end

endmodule

### rtl/vbmu_checker.sv
// Port-level checks for the video bank mapping unit, bound to the top level.
// Depends on video_bank_mapping_unit_top port names.
module vbmu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [8:0]  hit_mask_o,
  input logic [3:0]  first_bank_o,
  input logic [16:0] bank_offset_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_mask_o)
      && $stable(first_bank_o) && $stable(bank_offset_o))
    else $error("result beat changed while stalled");

  // input only stalls behind a stalled result beat
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no stalled result");

  // first bank is a real bank
  a_first_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> first_bank_o <= 4'd8)
    else $error("first_bank out of range");

  // no hit reports zero bank and offset
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hit_mask_o == 9'd0) |-> (first_bank_o == 4'd0) && (bank_offset_o == 17'd0))
    else $error("miss with nonzero bank or offset");

  // first bank is the lowest set bit of the hit mask
  a_first_lowest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hit_mask_o != 9'd0) && (first_bank_o <= 4'd8)
      |-> ((hit_mask_o >> first_bank_o) & 9'd1) == 9'd1
       && (hit_mask_o & ((9'd1 << first_bank_o) - 9'd1)) == 9'd0)
    else $error("first_bank is not the lowest hit");

endmodule

bind video_bank_mapping_unit_top vbmu_checker u_vbmu_checker (.*);

### verif/vbmu_check_pkg.sv
// Expected-result tracking for the video bank mapping unit bench: a bank control
// mirror, its own window decode and an in-order store of expected result beats.
// Depends on vbmu_pkg for region, mode, function and bank codes.
package vbmu_check_pkg;
  import vbmu_pkg::*;

  localparam logic [BIDX_W-1:0] BANK_A = 4'd0;
  localparam logic [BIDX_W-1:0] BANK_B = 4'd1;

  // writable bits per bank, A..I
  localparam logic [7:0] CTL_WRITABLE [NUM_BANKS] = '{
    8'h9b, 8'h9b, 8'h9f, 8'h9f, 8'h87, 8'h9f, 8'h9f, 8'h83, 8'h83
  };

  // one result beat
  typedef struct packed {
    logic [NUM_BANKS-1:0] hits;
    logic [BIDX_W-1:0]    first;
    logic [OFS_W-1:0]     offset;
    logic [1:0]           status;
    logic [CTL_W-1:0]     readback;
  } lookup_result_t;

  class bank_map_scoreboard;
    logic [CTL_W-1:0] ctl_bytes [NUM_BANKS];
    logic [1:0]       sub_status;
    lookup_result_t   expected_q [$];
    int unsigned      error_count;

    function new();
      foreach (ctl_bytes[i]) ctl_bytes[i] = '0;
      sub_status  = '0;
      error_count = 0;
    endfunction

    // window opened by control byte c of bank b; returns 0 when the bank is unmapped
    function bit window_for(input int unsigned b, input logic [CTL_W-1:0] c,
                            output logic [2:0] rg, output int unsigned base,
                            output int unsigned span);
      logic [2:0]  mode;
      int unsigned ofs;
      int unsigned o0;
      int unsigned o1;
      mode = c[2:0];
      ofs  = c[4:3];
      o0   = c[3];
      o1   = c[4];
      rg   = RG_LCDC;
      base = 0;
      span = 0;
      if (!c[7]) return 1'b0;
      if (b <= BANK_D) begin
        span = 'h20000;
        case (mode)
          MODE_0: begin rg = RG_LCDC; base = b * 'h20000; end
          MODE_1: begin rg = RG_BGA; base = ofs * 'h20000; end
          MODE_2: begin rg = (b >= BANK_C) ? RG_SUB : RG_OBJA; base = o0 * 'h20000; end
          MODE_3: begin rg = RG_TEX; base = ofs * 'h20000; end
          MODE_4: begin
            if (b == BANK_C) rg = RG_BGB;
            else if (b == BANK_D) rg = RG_OBJB;
            else return 1'b0;
          end
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      if (b == BANK_E) begin
        span = 'h10000;
        case (mode)
          MODE_0: begin rg = RG_LCDC; base = 'h80000; end
          MODE_1: rg = RG_BGA;
          MODE_2: rg = RG_OBJA;
          MODE_3: rg = RG_TPAL;
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      if (b == BANK_F || b == BANK_G) begin
        span = 'h4000;
        base = o0 * 'h4000 + o1 * 'h10000;
        case (mode)
          MODE_0: begin rg = RG_LCDC; base = (b == BANK_F) ? 'h90000 : 'h94000; end
          MODE_1: rg = RG_BGA;
          MODE_2: rg = RG_OBJA;
          MODE_3: rg = RG_TPAL;
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      if (b == BANK_H) begin
        span = 'h8000;
        case (mode)
          MODE_0: begin rg = RG_LCDC; base = 'h98000; end
          MODE_1: rg = RG_BGB;
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      if (b == BANK_I) begin
        span = 'h4000;
        case (mode)
          MODE_0: begin rg = RG_LCDC; base = 'ha0000; end
          MODE_1: begin rg = RG_BGB; base = 'h8000; end
          MODE_2: rg = RG_OBJB;
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // update the mirror for an accepted input beat and queue its expected result
    function void note_input(input logic f, input logic [BIDX_W-1:0] bidx,
                             input logic [CTL_W-1:0] val, input logic [2:0] region,
                             input logic [ADDR_W-1:0] addr);
      lookup_result_t r;
      logic [2:0]     rg;
      int unsigned    base;
      int unsigned    span;
      r = '0;
      if (f == FUNC_WRITE) begin
        if (bidx < NUM_BANKS) begin
          ctl_bytes[bidx] = val & CTL_WRITABLE[bidx];
          sub_status[0] = ctl_bytes[BANK_C][7] && (ctl_bytes[BANK_C][2:0] == MODE_2);
          sub_status[1] = ctl_bytes[BANK_D][7] && (ctl_bytes[BANK_D][2:0] == MODE_2);
        end
      end else begin
        // every covering bank sets its hit bit, the lowest one gives the offset
        for (int unsigned b = 0; b < NUM_BANKS; b++) begin
          if (!window_for(b, ctl_bytes[b], rg, base, span)) continue;
          if (rg != region || addr < base || addr - base >= span) continue;
          if (r.hits == '0) begin
            r.first  = BIDX_W'(b);
            r.offset = OFS_W'(addr - base);
          end
          r.hits[b] = 1'b1;
        end
      end
      r.status   = sub_status;
      r.readback = (bidx < NUM_BANKS) ? ctl_bytes[bidx] : '0;
      expected_q.push_back(r);
    endfunction

    function void compare_field(input string name, input int unsigned exp_val,
                                input int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        error_count++;
      end
    endfunction

    // compare an accepted result beat with the oldest expectation
    function void check_result(input lookup_result_t got);
      lookup_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation pending");
        error_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("hit_mask", exp_r.hits, got.hits);
      compare_field("first_bank", exp_r.first, got.first);
      compare_field("bank_offset", exp_r.offset, got.offset);
      compare_field("status_bits", exp_r.status, got.status);
      compare_field("control_readback", exp_r.readback, got.readback);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### verif/tb_top.sv
// Top-level bench for video_bank_mapping_unit_top: directed and random control
// writes and region lookups under sender idling and receiver stalls.
// Depends on vbmu_pkg and vbmu_check_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vbmu_pkg::*;
  import vbmu_check_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned PHASE_BEATS    = 225;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 func_i;
  logic [BIDX_W-1:0]    bank_index_i;
  logic [CTL_W-1:0]     control_value_i;
  logic [2:0]           region_i;
  logic [ADDR_W-1:0]    region_address_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [NUM_BANKS-1:0] hit_mask_o;
  logic [BIDX_W-1:0]    first_bank_o;
  logic [OFS_W-1:0]     bank_offset_o;
  logic [1:0]           status_bits_o;
  logic [CTL_W-1:0]     control_readback_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  bank_map_scoreboard sb = new();

  video_bank_mapping_unit_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .bank_index_i       (bank_index_i),
    .control_value_i    (control_value_i),
    .region_i           (region_i),
    .region_address_i   (region_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_mask_o         (hit_mask_o),
    .first_bank_o       (first_bank_o),
    .bank_offset_o      (bank_offset_o),
    .status_bits_o      (status_bits_o),
    .control_readback_o (control_readback_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // drive one input beat, holding it until accepted
  task automatic send_beat(input logic f, input logic [BIDX_W-1:0] bidx,
                           input logic [CTL_W-1:0] val, input logic [2:0] rg,
                           input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= f;
    bank_index_i     <= bidx;
    control_value_i  <= val;
    region_i         <= rg;
    region_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(f, bidx, val, rg, addr);
  endtask

  // random beat; most lookups aim at the edges or inside of a live bank window
  task automatic random_beat();
    logic              f;
    logic [BIDX_W-1:0] bidx;
    logic [CTL_W-1:0]  val;
    logic [2:0]        rg;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        win_rg;
    int unsigned       b;
    int unsigned       base;
    int unsigned       span;
    f    = ($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_XLATE;
    bidx = ($urandom_range(9) == 0) ? BIDX_W'($urandom_range(15, 9))
                                    : BIDX_W'($urandom_range(NUM_BANKS - 1));
    val  = CTL_W'($urandom);
    if ($urandom_range(3) != 0) val[7] = 1'b1;
    if ($urandom_range(1) == 0) val[2:0] = 3'($urandom_range(4));
    rg   = 3'($urandom);
    addr = ADDR_W'($urandom);
    if (f == FUNC_XLATE && $urandom_range(99) < 75) begin
      b = $urandom_range(NUM_BANKS - 1);
      if (sb.window_for(b, sb.ctl_bytes[b], win_rg, base, span)) begin
        rg = win_rg;
        case ($urandom_range(5))
          0:       addr = ADDR_W'(base);
          1:       addr = ADDR_W'(base + span - 1);
          2:       addr = ADDR_W'(base + span);
          3:       addr = ADDR_W'(base - 1);
          default: addr = ADDR_W'(base + $urandom_range(span - 1));
        endcase
      end
    end
    send_beat(f, bidx, val, rg, addr);
  endtask

  // result side: check accepted beats, stall at random
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result('{hit_mask_o, first_bank_o, bank_offset_o, status_bits_o,
                          control_readback_o});
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL video_bank_mapping_unit_top");
    $finish;
  end

  // main sequence
  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    func_i           <= FUNC_WRITE;
    bank_index_i     <= '0;
    control_value_i  <= '0;
    region_i         <= RG_LCDC;
    region_address_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, ignored bank index, overlaps, sub processor status,
    // disabled banks, extended palette and meaningless modes, address extremes
    send_beat(FUNC_XLATE, BANK_A, 8'h00, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, 4'hf, 8'hff, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_A, 8'h81, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_B, 8'h81, RG_LCDC, 20'h00000);
    send_beat(FUNC_XLATE, BANK_A, 8'h00, RG_BGA, 20'h1ffff);
    send_beat(FUNC_XLATE, BANK_B, 8'h00, RG_BGA, 20'h20000);
    send_beat(FUNC_WRITE, BANK_C, 8'h82, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_D, 8'h8a, RG_LCDC, 20'h00000);
    send_beat(FUNC_XLATE, BANK_D, 8'h00, RG_SUB, 20'h20000);
    send_beat(FUNC_WRITE, BANK_E, 8'h83, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_F, 8'h9b, RG_LCDC, 20'h00000);
    send_beat(FUNC_XLATE, BANK_F, 8'h00, RG_TPAL, 20'h14000);
    send_beat(FUNC_WRITE, BANK_G, 8'h05, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_H, 8'h81, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_I, 8'hff, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_I, 8'h81, RG_LCDC, 20'h00000);
    send_beat(FUNC_XLATE, BANK_I, 8'h00, RG_BGB, 20'h08000);
    send_beat(FUNC_WRITE, BANK_E, 8'h85, RG_LCDC, 20'h00000);
    send_beat(FUNC_XLATE, BANK_E, 8'h00, RG_TPAL, 20'h00000);
    send_beat(FUNC_WRITE, BANK_H, 8'h83, RG_LCDC, 20'h00000);
    send_beat(FUNC_WRITE, BANK_C, 8'h84, RG_LCDC, 20'h00000);
    send_beat(FUNC_XLATE, BANK_C, 8'h00, RG_BGB, 20'h00000);
    send_beat(FUNC_XLATE, 4'hc, 8'hff, RG_TPAL, 20'hfffff);
    send_beat(FUNC_WRITE, BANK_G, 8'h00, RG_LCDC, 20'h00000);

    // random: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      repeat (PHASE_BEATS) random_beat();
    end
    in_valid_i <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0)
      $display("PASS video_bank_mapping_unit_top");
    else
      $display("FAIL video_bank_mapping_unit_top");
    $finish;
  end

endmodule
